FILE: rtl/iidl_pkg.sv
// ----------------------------------------------------------------------------
// iidl_pkg: shared types and codes for the indexed insert/delete list
// Field widths of the transfer payloads, action and status codes, and the
// command word that the controller hands to the row of storage cells.
// ----------------------------------------------------------------------------
`default_nettype none

package iidl_pkg;

    localparam int ACT_W   = 2;
    localparam int POS_W   = 5;
    localparam int WORD_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;
    localparam int CAP_W   = 5;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [POS_W-1:0]  position;
        logic [WORD_W-1:0] item_data;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [WORD_W-1:0]  read_data;
        logic [COUNT_W-1:0] count;
    } t_out_item;

    // Command broadcast to every cell for one accepted action.
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [POS_W-1:0] pos;
    } t_cell_cmd;

endpackage

`default_nettype wire

FILE: rtl/iidl_cell.sv
// ----------------------------------------------------------------------------
// iidl_cell: one storage cell of the list
// Holds the entry at a fixed list index. On an insert it takes its left
// neighbor's word (or the new word at the insert point); on a delete it
// takes its right neighbor's word; otherwise it holds.
// ----------------------------------------------------------------------------
`default_nettype none

module iidl_cell #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int INDEX      = 0
) (
    input  wire                       i_clk,
    input  wire iidl_pkg::t_cell_cmd  i_cmd,
    input  wire  [DATA_WIDTH-1:0]     i_left,
    input  wire  [DATA_WIDTH-1:0]     i_right,
    input  wire  [DATA_WIDTH-1:0]     i_new,
    output logic [DATA_WIDTH-1:0]     o_q
);
    import iidl_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = (IDX_W > POS_W) ? IDX_W : POS_W;

    logic [CMP_W-1:0]      w_idx;
    logic [CMP_W-1:0]      w_pos;
    logic [DATA_WIDTH-1:0] r_q;
    logic [DATA_WIDTH-1:0] n_q;

    assign w_idx = CMP_W'(INDEX);
    assign w_pos = CMP_W'(i_cmd.pos);

    always_comb begin
        n_q = r_q;
        if (i_cmd.ins) begin
            if (w_idx > w_pos) begin
                n_q = i_left;
            end else if (w_idx == w_pos) begin
                n_q = i_new;
            end
        end else if (i_cmd.del) begin
            if (w_idx >= w_pos) begin
                n_q = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

FILE: rtl/iidl_ctrl.sv
// ----------------------------------------------------------------------------
// iidl_ctrl: list controller
// Keeps the entry count and the capacity register, checks each action,
// issues the shift command to the cells and registers the result transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module iidl_ctrl #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    input  wire iidl_pkg::t_in_item      i_in_item,
    output logic                         o_in_stall,
    input  wire                          i_cfg_valid,
    input  wire  [iidl_pkg::CAP_W-1:0]   i_cfg_data,
    output logic                         o_cfg_ready,
    input  wire  [DATA_WIDTH-1:0]        i_rd_word,
    output iidl_pkg::t_cell_cmd          o_cmd,
    output logic                         o_out_valid,
    output iidl_pkg::t_out_item          o_out_item,
    input  wire                          i_out_stall
);
    import iidl_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int TMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int CM_W  = (TMP_W > CAP_W) ? TMP_W : CAP_W;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CAP_W-1:0] r_cap;
    logic             r_out_valid;
    t_out_item        r_out_item;
    t_out_item        n_out_item;

    logic             w_accept;
    logic [CM_W-1:0]  w_cnt;
    logic [CM_W-1:0]  w_pos;
    logic [CM_W-1:0]  w_cap;
    logic [CM_W-1:0]  w_depth;
    logic [CM_W-1:0]  w_eff_cap;
    logic             w_full;
    logic             w_empty;
    logic [STAT_W-1:0] w_status;
    logic [WORD_W-1:0] w_rd;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_accept    = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign w_cnt   = CM_W'(r_count);
    assign w_pos   = CM_W'(i_in_item.position);
    assign w_cap   = CM_W'(r_cap);
    assign w_depth = CM_W'(DEPTH);

    // A capacity of zero acts as one, and anything above the depth as the depth.
    always_comb begin
        if (w_cap == '0) begin
            w_eff_cap = CM_W'(1);
        end else if (w_cap > w_depth) begin
            w_eff_cap = w_depth;
        end else begin
            w_eff_cap = w_cap;
        end
    end

    assign w_full  = (w_cnt >= w_eff_cap) || (w_cnt >= w_depth);
    assign w_empty = (r_count == '0);

    always_comb begin
        w_status = ST_OK;
        w_rd     = '0;
        o_cmd    = '0;
        n_count  = r_count;
        o_cmd.pos = i_in_item.position;
        case (i_in_item.action)
            ACT_INSERT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else if (w_pos > w_cnt) begin
                    w_status = ST_BADPOS;
                end else begin
                    o_cmd.ins = w_accept;
                    n_count   = r_count + CNT_W'(1);
                end
            end
            ACT_DELETE: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (w_pos >= w_cnt) begin
                    w_status = ST_BADPOS;
                end else begin
                    o_cmd.del = w_accept;
                    n_count   = r_count - CNT_W'(1);
                end
            end
            ACT_READ: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (w_pos >= w_cnt) begin
                    w_status = ST_BADPOS;
                end else begin
                    w_rd = WORD_W'(i_rd_word);
                end
            end
            default: begin
                w_status = ST_BADPOS;
            end
        endcase
        n_out_item.status    = w_status;
        n_out_item.read_data = w_rd;
        n_out_item.count     = COUNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

FILE: rtl/indexed_insert_delete_list.sv
// ----------------------------------------------------------------------------
// indexed_insert_delete_list: bounded ordered list with indexed access
// Top level: a row of storage cells driven by the list controller.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item): one action per
//   transfer, insert, delete or read at a list position.
//   Output channel (o_out_valid / i_out_stall / o_out_item): exactly one
//   result per action with status, read word and the count afterwards.
//   Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data): writes
//   the capacity limit; write it only while no action is in flight.
//   Every cell shifts at once, and the result
//   appears in the output register the cycle after the input transfer.
//   A new action is taken in every cycle while the output moves, so the
//   throughput is one action per cycle.
//   When the receiver stalls, the result holds in the output register and
//   the input stalls too, once that register is full.
//   Synchronous reset empties the list and sets the capacity to 16; the
//   stored words are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_insert_delete_list #(
    parameter int DEPTH      = iidl_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = iidl_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    input  wire iidl_pkg::t_in_item      i_in_item,
    output logic                         o_in_stall,
    output logic                         o_out_valid,
    output iidl_pkg::t_out_item          o_out_item,
    input  wire                          i_out_stall,
    input  wire                          i_cfg_valid,
    input  wire  [iidl_pkg::CAP_W-1:0]   i_cfg_data,
    output logic                         o_cfg_ready
);
    import iidl_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);

    t_cell_cmd             w_cmd;
    logic [DATA_WIDTH-1:0] w_new_word;
    logic [DATA_WIDTH-1:0] w_cell_q [DEPTH];
    logic [IDX_W-1:0]      w_rd_idx;
    logic [DATA_WIDTH-1:0] w_rd_word;

    assign w_new_word = DATA_WIDTH'(i_in_item.item_data);
    assign w_rd_idx   = IDX_W'(i_in_item.position);
    // Only positions below the count are used, so the index is in range then.
    assign w_rd_word  = w_cell_q[w_rd_idx];

    iidl_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_rd_word   (w_rd_word),
        .o_cmd       (w_cmd),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid
            assign w_left = w_cell_q[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_cell_q[g];
        end else begin : g_inner
            assign w_right = w_cell_q[g+1];
        end

        iidl_cell #(
            .DEPTH      (DEPTH),
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .i_new   (w_new_word),
            .o_q     (w_cell_q[g])
        );
    end

endmodule

`default_nettype wire

FILE: rtl/iidl_checker.sv
// ----------------------------------------------------------------------------
// iidl_checker: port-level checks for the indexed insert/delete list
// Watches the top level's ports and flags results that cannot occur.
// ----------------------------------------------------------------------------
`default_nettype none

module iidl_checker #(
    parameter int DEPTH = 16
) (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_in_valid,
    input wire iidl_pkg::t_in_item      i_in_item,
    input wire                          o_in_stall,
    input wire                          o_out_valid,
    input wire iidl_pkg::t_out_item     o_out_item,
    input wire                          i_out_stall
);
    import iidl_pkg::*;

    // A stalled action stays in place until the block takes it.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_item))
        else $error("action changed while stalled");

    // A stalled result stays in place until the receiver takes it.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // Only a successful read carries a nonzero data word.
    a_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_OK |-> o_out_item.read_data == '0)
        else $error("refused action returned data");

    // An empty report means the list held nothing and still holds nothing.
    a_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == ST_EMPTY |-> o_out_item.count == '0)
        else $error("empty status with nonzero count");

    // The count never exceeds the number of cells.
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_out_item.count) <= DEPTH)
        else $error("count above depth");

endmodule

bind indexed_insert_delete_list iidl_checker #(.DEPTH(DEPTH)) u_iidl_checker (.*);

`default_nettype wire
